// File: sv/grouped_diagonal_scan_generator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grouped diagonal scan generator
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef GROUPED_DIAGONAL_SCAN_GENERATOR_UNIT_MACROS_SVH
`define GROUPED_DIAGONAL_SCAN_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define GDSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GDSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/gdsg_pkg.sv
// ---------------------------------------------------------------------------
// gdsg_pkg
// Types, constants, subblock shape table and diagonal step function.
// ---------------------------------------------------------------------------
`default_nettype none

package gdsg_pkg;

	localparam int ZERO_OUT_SIZE = 32;
	localparam int LOG2_MAX      = 6;
	localparam int CFG_W         = 3;
	localparam int IDX_W         = 1;
	localparam int ZO_W          = $clog2(ZERO_OUT_SIZE + 1);
	localparam int CG_W          = 5;  // subblock side up to 16
	localparam int CNT_W         = (ZO_W > CG_W) ? ZO_W : CG_W;
	localparam int BW_W          = LOG2_MAX + 1;
	localparam int POS_W         = 12;
	localparam int SCAN_W        = 10;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_TDATA_W   = 24;

	typedef logic [CFG_W-1:0] log2_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [IDX_W-1:0] {
		REG_LOG2_WIDTH  = 1'b0,
		REG_LOG2_HEIGHT = 1'b1
	} reg_idx_t;

	// subblock log2 width / height by [log2 width][log2 height]
	localparam log2_t SBB_LOG2_W [7][7] = '{
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
		'{3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2}
	};

	localparam log2_t SBB_LOG2_H [7][7] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4},
		'{3'd0, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2}
	};

	typedef struct packed {
		log2_t lw;
		log2_t cgw_log2;
		log2_t cgh_log2;
		cnt_t  cgw;
		cnt_t  cgh;
		cnt_t  wg;
		cnt_t  hg;
	} geom_t;

	typedef struct packed {
		logic [POS_W-1:0]  block_position;
		logic [SCAN_W-1:0] scan_index;
		logic              last_position;
	} result_t;

	typedef struct packed {
		cnt_t row;
		cnt_t col;
	} coord_t;

	// one up-right diagonal step inside a w by h grid
	function automatic coord_t diag_step(cnt_t row, cnt_t col, cnt_t w, cnt_t h);
		logic [CNT_W:0] r;
		coord_t         nxt;
		r = {1'b0, row} + {1'b0, col} + {{CNT_W{1'b0}}, 1'b1};
		if (col == w - 1'b1 || row == '0) begin
			if (r >= {1'b0, h}) begin
				nxt.row = h - 1'b1;
				nxt.col = CNT_W'(r - {1'b0, h} + {{CNT_W{1'b0}}, 1'b1});
			end else begin
				nxt.row = r[CNT_W-1:0];
				nxt.col = '0;
			end
		end else begin
			nxt.row = row - 1'b1;
			nxt.col = col + 1'b1;
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

// File: sv/gdsg_geom.sv
// ---------------------------------------------------------------------------
// gdsg_geom
// Derives subblock shape and zero-out group counts from the block size.
// ---------------------------------------------------------------------------
`default_nettype none

module gdsg_geom (
	input  wire gdsg_pkg::log2_t log2_width,
	input  wire gdsg_pkg::log2_t log2_height,
	output gdsg_pkg::geom_t      geom
);

	gdsg_pkg::log2_t             lw;
	gdsg_pkg::log2_t             lh;
	gdsg_pkg::log2_t             cgw_log2;
	gdsg_pkg::log2_t             cgh_log2;
	logic [gdsg_pkg::BW_W-1:0]   bw;
	logic [gdsg_pkg::BW_W-1:0]   bh;
	gdsg_pkg::cnt_t              zw;
	gdsg_pkg::cnt_t              zh;
	gdsg_pkg::cnt_t              wg_raw;
	gdsg_pkg::cnt_t              hg_raw;

	always_comb begin
		// size code seven behaves as six
		lw = (log2_width > gdsg_pkg::log2_t'(gdsg_pkg::LOG2_MAX)) ?
			gdsg_pkg::log2_t'(gdsg_pkg::LOG2_MAX) : log2_width;
		lh = (log2_height > gdsg_pkg::log2_t'(gdsg_pkg::LOG2_MAX)) ?
			gdsg_pkg::log2_t'(gdsg_pkg::LOG2_MAX) : log2_height;
		cgw_log2 = gdsg_pkg::SBB_LOG2_W[lw][lh];
		cgh_log2 = gdsg_pkg::SBB_LOG2_H[lw][lh];
		bw = gdsg_pkg::BW_W'(1) << lw;
		bh = gdsg_pkg::BW_W'(1) << lh;
		zw = (bw < gdsg_pkg::BW_W'(gdsg_pkg::ZERO_OUT_SIZE)) ? gdsg_pkg::cnt_t'(bw) :
			gdsg_pkg::cnt_t'(gdsg_pkg::ZERO_OUT_SIZE);
		zh = (bh < gdsg_pkg::BW_W'(gdsg_pkg::ZERO_OUT_SIZE)) ? gdsg_pkg::cnt_t'(bh) :
			gdsg_pkg::cnt_t'(gdsg_pkg::ZERO_OUT_SIZE);
		wg_raw = zw >> cgw_log2;
		hg_raw = zh >> cgh_log2;

		geom.lw       = lw;
		geom.cgw_log2 = cgw_log2;
		geom.cgh_log2 = cgh_log2;
		geom.cgw      = gdsg_pkg::cnt_t'(1) << cgw_log2;
		geom.cgh      = gdsg_pkg::cnt_t'(1) << cgh_log2;
		// region narrower than a subblock still scans one group
		geom.wg       = (wg_raw == '0) ? gdsg_pkg::cnt_t'(1) : wg_raw;
		geom.hg       = (hg_raw == '0) ? gdsg_pkg::cnt_t'(1) : hg_raw;
	end

endmodule

`default_nettype wire

// File: sv/gdsg_walk.sv
// ---------------------------------------------------------------------------
// gdsg_walk
// Scan position state, current result and diagonal advance.
// ---------------------------------------------------------------------------
`default_nettype none

module gdsg_walk (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire gdsg_pkg::geom_t  geom,
	input  wire                   clear,
	input  wire                   advance,
	input  wire                   restart,
	output gdsg_pkg::result_t     result
);

	gdsg_pkg::cnt_t               group_row_q;
	gdsg_pkg::cnt_t               group_col_q;
	gdsg_pkg::cnt_t               inner_row_q;
	gdsg_pkg::cnt_t               inner_col_q;
	logic [gdsg_pkg::SCAN_W-1:0]  scan_q;

	gdsg_pkg::cnt_t               grow;
	gdsg_pkg::cnt_t               gcol;
	gdsg_pkg::cnt_t               irow;
	gdsg_pkg::cnt_t               icol;
	logic [gdsg_pkg::SCAN_W-1:0]  scan;
	logic [gdsg_pkg::POS_W-1:0]   row;
	logic [gdsg_pkg::POS_W-1:0]   col;
	logic                         inner_end;
	logic                         group_end;
	gdsg_pkg::coord_t             inner_nxt;
	gdsg_pkg::coord_t             group_nxt;

	always_comb begin
		// restart takes effect before this word's position is formed
		grow = restart ? '0 : group_row_q;
		gcol = restart ? '0 : group_col_q;
		irow = restart ? '0 : inner_row_q;
		icol = restart ? '0 : inner_col_q;
		scan = restart ? '0 : scan_q;

		row = (gdsg_pkg::POS_W'(grow) << geom.cgh_log2) + gdsg_pkg::POS_W'(irow);
		col = (gdsg_pkg::POS_W'(gcol) << geom.cgw_log2) + gdsg_pkg::POS_W'(icol);
		inner_end = (irow == geom.cgh - 1'b1) && (icol == geom.cgw - 1'b1);
		group_end = (grow == geom.hg - 1'b1) && (gcol == geom.wg - 1'b1);

		result.block_position = (row << geom.lw) + col;
		result.scan_index     = scan;
		result.last_position  = inner_end && group_end;

		inner_nxt = gdsg_pkg::diag_step(irow, icol, geom.cgw, geom.cgh);
		group_nxt = gdsg_pkg::diag_step(grow, gcol, geom.wg, geom.hg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_row_q <= '0;
			group_col_q <= '0;
			inner_row_q <= '0;
			inner_col_q <= '0;
			scan_q      <= '0;
		end else if (clear || (advance && inner_end && group_end)) begin
			// wrap to the first position
			group_row_q <= '0;
			group_col_q <= '0;
			inner_row_q <= '0;
			inner_col_q <= '0;
			scan_q      <= '0;
		end else if (advance) begin
			if (inner_end) begin
				inner_row_q <= '0;
				inner_col_q <= '0;
				group_row_q <= group_nxt.row;
				group_col_q <= group_nxt.col;
			end else begin
				inner_row_q <= inner_nxt.row;
				inner_col_q <= inner_nxt.col;
				group_row_q <= grow;
				group_col_q <= gcol;
			end
			scan_q <= scan + 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: sv/grouped_diagonal_scan_generator_unit.sv
// ---------------------------------------------------------------------------
// grouped_diagonal_scan_generator_unit
// Emits one coefficient position per input word in grouped up-right
// diagonal scan order over the top-left zero-out region of the block.
// ---------------------------------------------------------------------------
//  channel  | dir | contents
//  s_*      | in  | tdata[0] restart
//  m_*      | out | tdata[11:0] block_position, [21:12] scan index;
//           |     | tlast last_position
//  cfg_*    | in  | index 0 log2 block width, index 1 log2 block height
//
// One word per cycle while the sink does not stall; the result is registered
// in the output register as the input word is taken. The output register is
// the only stage, so s_tready stays high while the register is empty or being
// emptied. Reset restores 4x4 blocks and scan position zero; a size write also
// returns the scan to position zero.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grouped_diagonal_scan_generator_unit_macros.svh"

module grouped_diagonal_scan_generator_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [gdsg_pkg::IDX_W-1:0]          cfg_index,
	input  wire [gdsg_pkg::CFG_W-1:0]          cfg_data,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [gdsg_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] restart
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [11:0] block_position, [21:12] scan index, [23:22] zero
	output logic [gdsg_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast    // last_position
);

	gdsg_pkg::log2_t    log2_width_q;
	gdsg_pkg::log2_t    log2_height_q;
	gdsg_pkg::geom_t    geom;
	gdsg_pkg::result_t  result;
	gdsg_pkg::result_t  res_q;
	logic               out_valid_q;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_width_q  <= gdsg_pkg::log2_t'(2);
			log2_height_q <= gdsg_pkg::log2_t'(2);
		end else if (cfg_we) begin
			unique case (gdsg_pkg::reg_idx_t'(cfg_index))
				gdsg_pkg::REG_LOG2_WIDTH:  log2_width_q  <= cfg_data;
				gdsg_pkg::REG_LOG2_HEIGHT: log2_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gdsg_geom u_geom (
		.log2_width  (log2_width_q),
		.log2_height (log2_height_q),
		.geom        (geom)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	gdsg_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.clear   (cfg_we),
		.advance (accept),
		.restart (s_tdata[0]),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the word while the sink stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.scan_index, res_q.block_position};
	assign m_tlast  = res_q.last_position;

	`GDSG_ASSERT_NOW(a_ready_when_empty, !out_valid_q, s_tready, "empty output stage not ready")
	`GDSG_ASSERT_NEXT(a_accept_fills, accept, m_tvalid, "accepted word produced no result")
	`GDSG_ASSERT_NEXT(a_restart_zero, accept && s_tdata[0], m_tdata[21:12] == '0, "restart did not emit scan index zero")
	`GDSG_ASSERT_NEXT(a_wrap_zero, accept && result.last_position && !cfg_we ##1 accept, m_tdata[21:12] == '0, "scan did not wrap after the last position")

endmodule

`default_nettype wire
